@@ hdl/odometry_velocity_estimator_defines.svh @@
// Assertion macros for the odometry velocity estimator checker.
`ifndef ODOMETRY_VELOCITY_ESTIMATOR_DEFINES_SVH
`define ODOMETRY_VELOCITY_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define OVE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("odometry velocity estimator check failed");

// Next-cycle implication.
`define OVE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("odometry velocity estimator check failed");

`endif

@@ hdl/ove_pkg.sv @@
// Shared types, constants and tables for the odometry velocity estimator.
`default_nettype none
package ove_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam int CW = 40;
    localparam int ZW = 36;
    localparam int DW = 96;

    localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CW-1:0] KINV_Q30    = 40'sd652032874;
    localparam logic signed [33:0]   NS_PER_S    = 34'sd1000000000;
    localparam logic signed [16:0]   PI_Q13      = 17'sd25736;
    localparam logic signed [16:0]   TWO_PI_Q13  = 17'sd51472;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DT  = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    localparam logic [5:0] QMUL_LAST = 6'd4;
    localparam logic [5:0] PMUL_LAST = 6'd4;
    localparam logic [5:0] RMUL_LAST = 6'd2;
    localparam logic [5:0] RDIV_LAST = 6'd31;
    localparam logic [1:0] RATE_LAST = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_QMUL, OP_VINIT, OP_VITER, OP_VFIN, OP_RINIT, OP_RITER,
        OP_RFIN, OP_PMUL, OP_RSET, OP_RMUL, OP_RCHK, OP_RDIV, OP_RDONE, OP_FINISH
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] idx;
        logic [1:0] k;
    } t_cmd;

    typedef struct packed {
        logic dt_pos;
        logic out_busy;
    } t_sts;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            5'd24: v = 30'd63;
            5'd25: v = 30'd31;
            5'd26: v = 30'd15;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hdl/ove_ctrl.sv @@
// Sequencing state machine for the odometry velocity estimator.
`default_nettype none
module ove_ctrl #(
    parameter int CORDIC_STEPS = ove_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  ove_pkg::t_sts      i_sts,
    output ove_pkg::t_cmd      o_cmd,
    output logic               o_ready
);
    import ove_pkg::*;

    localparam logic [5:0] CS_LAST = 6'(CORDIC_STEPS - 1);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_QMUL   = 15'b000000000000010,
        S_VINIT  = 15'b000000000000100,
        S_VITER  = 15'b000000000001000,
        S_VFIN   = 15'b000000000010000,
        S_RINIT  = 15'b000000000100000,
        S_RITER  = 15'b000000001000000,
        S_RFIN   = 15'b000000010000000,
        S_PMUL   = 15'b000000100000000,
        S_RSET   = 15'b000001000000000,
        S_RMUL   = 15'b000010000000000,
        S_RCHK   = 15'b000100000000000,
        S_RDIV   = 15'b001000000000000,
        S_RDONE  = 15'b010000000000000,
        S_FINISH = 15'b100000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic [1:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_k     = r_k;
        o_cmd.op  = OP_NONE;
        o_cmd.idx = r_cnt[4:0];
        o_cmd.k   = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_QMUL;
                    n_cnt    = '0;
                end
            end
            S_QMUL: begin
                o_cmd.op = OP_QMUL;
                if (r_cnt == QMUL_LAST) begin
                    n_state = S_VINIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_VINIT: begin
                o_cmd.op = OP_VINIT;
                n_state  = S_VITER;
            end
            S_VITER: begin
                o_cmd.op = OP_VITER;
                if (r_cnt == CS_LAST) begin
                    n_state = S_VFIN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_VFIN: begin
                o_cmd.op = OP_VFIN;
                n_state  = i_sts.dt_pos ? S_RINIT : S_FINISH;
            end
            S_RINIT: begin
                o_cmd.op = OP_RINIT;
                n_state  = S_RITER;
            end
            S_RITER: begin
                o_cmd.op = OP_RITER;
                if (r_cnt == CS_LAST) begin
                    n_state = S_RFIN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_RFIN: begin
                o_cmd.op = OP_RFIN;
                n_state  = S_PMUL;
            end
            S_PMUL: begin
                o_cmd.op = OP_PMUL;
                if (r_cnt == PMUL_LAST) begin
                    n_state = S_RSET;
                    n_cnt   = '0;
                    n_k     = '0;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_RSET: begin
                o_cmd.op = OP_RSET;
                n_state  = S_RMUL;
            end
            S_RMUL: begin
                o_cmd.op = OP_RMUL;
                if (r_cnt == RMUL_LAST) begin
                    n_state = S_RCHK;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_RCHK: begin
                o_cmd.op = OP_RCHK;
                n_state  = S_RDIV;
            end
            S_RDIV: begin
                o_cmd.op = OP_RDIV;
                if (r_cnt == RDIV_LAST) begin
                    n_state = S_RDONE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_RDONE: begin
                o_cmd.op = OP_RDONE;
                if (r_k == RATE_LAST) begin
                    n_state = S_FINISH;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_RSET;
                end
            end
            S_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

@@ hdl/ove_dp.sv @@
// Datapath: shared multiplier, shared CORDIC, serial divider, state and output register.
`default_nettype none
module ove_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  ove_pkg::t_cmd      i_cmd,
    output ove_pkg::t_sts      o_sts,
    input  wire logic [191:0]  i_data,
    input  wire logic          i_m_tready,
    output logic               o_m_tvalid,
    output logic [95:0]        o_m_tdata,
    output logic [1:0]         o_m_tuser
);
    import ove_pkg::*;

    logic signed [31:0] r_px, r_py, r_lpx, r_lpy;
    logic signed [15:0] r_qx, r_qy, r_qz, r_qw, r_lyaw, r_yaw;
    logic [31:0]        r_sec, r_lsec;
    logic [29:0]        r_ns, r_lns;
    logic signed [63:0] r_p, r_acc, r_dt, r_nx, r_ny;
    logic signed [33:0] r_num, r_den;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic               r_zero, r_rneg, r_neg, r_presat, r_sat;
    logic signed [16:0] r_dyaw;
    logic signed [31:0] r_c, r_s;
    logic [61:0]        r_mag;
    logic [DW-1:0]      r_d, r_n, r_rem;
    logic [31:0]        r_nlo, r_q;
    logic [31:0]        r_vx, r_vy, r_wr;
    logic               r_ov;
    logic [95:0]        r_otd;
    logic [1:0]         r_ost;

    logic signed [32:0]   w_secd, w_dx, w_dy;
    logic signed [30:0]   w_nsd;
    logic signed [33:0]   w_ma, w_mb;
    logic signed [67:0]   w_prod;
    logic signed [63:0]   w_sum;
    logic signed [CW-1:0] w_xs, w_ys, w_xf, w_yf, w_cr, w_sr, w_xi, w_yi;
    logic signed [ZW-1:0] w_at, w_zr, w_th, w_zi;
    logic                 w_tneg;
    logic signed [15:0]   w_yaw;
    logic signed [16:0]   w_dyw;
    logic signed [18:0]   w_mean;
    logic signed [63:0]   w_rnum, w_rmag;
    logic [DW-1:0]        w_t;
    logic [31:0]          w_lim, w_qv, w_val;
    logic                 w_s, w_dtpos;

    always_comb begin
        w_secd = $signed({1'b0, r_sec}) - $signed({1'b0, r_lsec});
        w_nsd  = $signed({1'b0, r_ns}) - $signed({1'b0, r_lns});
        w_dx   = $signed({r_px[31], r_px}) - $signed({r_lpx[31], r_lpx});
        w_dy   = $signed({r_py[31], r_py}) - $signed({r_lpy[31], r_lpy});
        w_sum  = r_acc + r_p;
        w_dtpos = !r_dt[63] && (r_dt != 64'sd0);
    end

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_QMUL: begin
                case (i_cmd.idx)
                    5'd0: begin
                        w_ma = {{18{r_qw[15]}}, r_qw};
                        w_mb = {{18{r_qz[15]}}, r_qz};
                    end
                    5'd1: begin
                        w_ma = {{18{r_qx[15]}}, r_qx};
                        w_mb = {{18{r_qy[15]}}, r_qy};
                    end
                    5'd2: begin
                        w_ma = {{18{r_qy[15]}}, r_qy};
                        w_mb = {{18{r_qy[15]}}, r_qy};
                    end
                    5'd3: begin
                        w_ma = {{18{r_qz[15]}}, r_qz};
                        w_mb = {{18{r_qz[15]}}, r_qz};
                    end
                    default: begin
                        w_ma = {w_secd[32], w_secd};
                        w_mb = NS_PER_S;
                    end
                endcase
            end
            OP_PMUL: begin
                case (i_cmd.idx)
                    5'd0: begin
                        w_ma = {{2{r_c[31]}}, r_c};
                        w_mb = {w_dx[32], w_dx};
                    end
                    5'd1: begin
                        w_ma = {{2{r_s[31]}}, r_s};
                        w_mb = {w_dy[32], w_dy};
                    end
                    5'd2: begin
                        w_ma = {{2{r_s[31]}}, r_s};
                        w_mb = {w_dx[32], w_dx};
                    end
                    default: begin
                        w_ma = {{2{r_c[31]}}, r_c};
                        w_mb = {w_dy[32], w_dy};
                    end
                endcase
            end
            OP_RMUL: begin
                w_mb = NS_PER_S;
                if (i_cmd.idx == 5'd0) begin
                    w_ma = $signed({3'b000, r_mag[30:0]});
                end else begin
                    w_ma = $signed({3'b000, r_mag[61:31]});
                end
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_prod = w_ma * w_mb;
    end

    // CORDIC micro-rotation and helpers
    always_comb begin
        w_xs = r_x >>> i_cmd.idx;
        w_ys = r_y >>> i_cmd.idx;
        w_at = $signed({{(ZW-30){1'b0}}, atan_q30(i_cmd.idx)});

        w_xi = {{(CW-34){r_den[33]}}, r_den};
        w_yi = {{(CW-34){r_num[33]}}, r_num};
        w_zi = '0;
        if (r_den[33]) begin
            w_zi = r_num[33] ? -PI_Q30 : PI_Q30;
            w_xi = -w_xi;
            w_yi = -w_yi;
        end

        w_zr = (r_z + 36'sd65536) >>> 17;
        if (w_zr > 36'sd32767) begin
            w_yaw = 16'sh7fff;
        end else if (w_zr < -36'sd32768) begin
            w_yaw = 16'sh8000;
        end else begin
            w_yaw = w_zr[15:0];
        end
        if (r_zero) begin
            w_yaw = '0;
        end
        w_dyw = $signed({w_yaw[15], w_yaw}) - $signed({r_lyaw[15], r_lyaw});
        if (w_dyw > PI_Q13) begin
            w_dyw = w_dyw - TWO_PI_Q13;
        end else if (w_dyw < -PI_Q13) begin
            w_dyw = w_dyw + TWO_PI_Q13;
        end

        w_mean = $signed({{2{r_lyaw[15]}}, r_lyaw, 1'b0})
               + $signed({{2{r_dyaw[16]}}, r_dyaw});
        w_th   = -($signed({{(ZW-19){w_mean[18]}}, w_mean}) <<< 16);
        w_tneg = 1'b0;
        for (int k = 0; k < 2; k++) begin
            if (w_th > HALF_PI_Q30) begin
                w_th   = w_th - PI_Q30;
                w_tneg = ~w_tneg;
            end else if (w_th < -HALF_PI_Q30) begin
                w_th   = w_th + PI_Q30;
                w_tneg = ~w_tneg;
            end
        end

        w_xf = r_rneg ? -r_x : r_x;
        w_yf = r_rneg ? -r_y : r_y;
        w_cr = (w_xf + 40'sd2) >>> 2;
        w_sr = (w_yf + 40'sd2) >>> 2;
    end

    // rate helpers
    always_comb begin
        case (i_cmd.k)
            2'd0:    w_rnum = r_nx;
            2'd1:    w_rnum = r_ny;
            default: w_rnum = $signed({{44{r_dyaw[16]}}, r_dyaw, 3'b000});
        endcase
        w_rmag = w_rnum[63] ? -w_rnum : w_rnum;
        w_t    = {r_rem[DW-2:0], r_nlo[31]};
        w_lim  = r_neg ? 32'h8000_0000 : 32'h7fff_ffff;
        w_s    = r_presat || (r_q > w_lim);
        w_qv   = w_s ? w_lim : r_q;
        w_val  = r_neg ? (32'd0 - w_qv) : w_qv;
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_px  <= i_data[31:0];
                r_py  <= i_data[63:32];
                r_qx  <= i_data[79:64];
                r_qy  <= i_data[95:80];
                r_qz  <= i_data[111:96];
                r_qw  <= i_data[127:112];
                r_sec <= i_data[159:128];
                r_ns  <= i_data[189:160];
                r_sat <= 1'b0;
            end
            OP_QMUL: begin
                r_p <= w_prod[63:0];
                case (i_cmd.idx)
                    5'd1, 5'd3: r_acc <= r_p;
                    5'd2:       r_num <= {w_sum[32:0], 1'b0};
                    5'd4:       r_den <= 34'sd1073741824 - $signed({w_sum[32:0], 1'b0});
                    default: begin
                    end
                endcase
            end
            OP_VINIT: begin
                r_dt   <= r_p + {{33{w_nsd[30]}}, w_nsd};
                r_zero <= (r_num == 34'sd0) && (r_den == 34'sd0);
                r_x    <= w_xi;
                r_y    <= w_yi;
                r_z    <= w_zi;
            end
            OP_VITER: begin
                if (!r_y[CW-1]) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_at;
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_at;
                end
            end
            OP_VFIN: begin
                r_yaw  <= w_yaw;
                r_dyaw <= w_dyw;
            end
            OP_RINIT: begin
                r_x    <= KINV_Q30;
                r_y    <= '0;
                r_z    <= w_th;
                r_rneg <= w_tneg;
            end
            OP_RITER: begin
                if (!r_z[ZW-1]) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_at;
                end
            end
            OP_RFIN: begin
                r_c <= w_cr[31:0];
                r_s <= w_sr[31:0];
            end
            OP_PMUL: begin
                r_p <= w_prod[63:0];
                case (i_cmd.idx)
                    5'd1, 5'd3: r_acc <= r_p;
                    5'd2:       r_nx  <= r_acc - r_p;
                    5'd4:       r_ny  <= w_sum;
                    default: begin
                    end
                endcase
            end
            OP_RSET: begin
                r_neg <= w_rnum[63];
                r_mag <= w_rmag[61:0];
                if (i_cmd.k == RATE_LAST) begin
                    r_d <= {32'd0, r_dt};
                end else begin
                    r_d <= {4'd0, r_dt, 28'd0};
                end
            end
            OP_RMUL: begin
                r_p <= w_prod[63:0];
                case (i_cmd.idx)
                    5'd1:    r_n <= {32'd0, r_p} + {1'b0, r_d[DW-1:1]};
                    5'd2:    r_n <= r_n + {1'b0, r_p, 31'd0};
                    default: begin
                    end
                endcase
            end
            OP_RCHK: begin
                r_presat <= ({32'd0, r_n[DW-1:32]} >= r_d);
                r_rem    <= {32'd0, r_n[DW-1:32]};
                r_nlo    <= r_n[31:0];
                r_q      <= '0;
            end
            OP_RDIV: begin
                r_nlo <= {r_nlo[30:0], 1'b0};
                if (w_t >= r_d) begin
                    r_rem <= w_t - r_d;
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= w_t;
                    r_q   <= {r_q[30:0], 1'b0};
                end
            end
            OP_RDONE: begin
                case (i_cmd.k)
                    2'd0:    r_vx <= w_val;
                    2'd1:    r_vy <= w_val;
                    default: r_wr <= w_val;
                endcase
                if (w_s) begin
                    r_sat <= 1'b1;
                end
            end
            OP_FINISH: begin
                if (w_dtpos) begin
                    r_otd <= {r_wr, r_vy, r_vx};
                    r_ost <= r_sat ? ST_SAT : ST_OK;
                end else begin
                    r_otd <= '0;
                    r_ost <= ST_DT;
                end
            end
            default: begin
            end
        endcase
    end

    // previous sample and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpx  <= '0;
            r_lpy  <= '0;
            r_lyaw <= '0;
            r_lsec <= '0;
            r_lns  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cmd.op == OP_FINISH) begin
                r_lpx  <= r_px;
                r_lpy  <= r_py;
                r_lyaw <= r_yaw;
                r_lsec <= r_sec;
                r_lns  <= r_ns;
                r_ov   <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_sts.dt_pos   = w_dtpos;
    assign o_sts.out_busy = r_ov && !i_m_tready;
    assign o_m_tvalid     = r_ov;
    assign o_m_tdata      = r_otd;
    assign o_m_tuser      = r_ost;

endmodule
`default_nettype wire

@@ hdl/odometry_velocity_estimator.sv @@
// Top level of the odometry velocity estimator.
// Sequence: a quaternion multiply phase and a vectoring CORDIC pass; when the time step is
// positive, a rotation CORDIC pass, a position multiply phase and, per rate (three rates), a
// multiply phase and a divider of 32 steps; otherwise the item goes straight to finishing.
// One item in flight; the next input is taken while a result waits, and an item finishes
// once the prior result is taken. Sync active-low reset clears prior sample and output valid.
`default_nettype none
module odometry_velocity_estimator #(
    parameter int CORDIC_STEPS = ove_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    // pos_x[31:0] pos_y[63:32] quat_x[79:64] quat_y[95:80] quat_z[111:96]
    // quat_w[127:112] stamp_seconds[159:128] stamp_nanoseconds[189:160]
    input  wire logic [191:0]  i_s_tdata,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    // vel_x[31:0] vel_y[63:32] yaw_rate[95:64]
    output logic [95:0]        o_m_tdata,
    // status[1:0]
    output logic [1:0]         o_m_tuser
);
    import ove_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    ove_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_s_tvalid && w_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_ready (w_ready)
    );

    ove_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_data     (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    assign o_s_tready = w_ready;

endmodule
`default_nettype wire

@@ hdl/ove_checker.sv @@
// Port-level checker for the odometry velocity estimator, bound to the top level.
`default_nettype none
`include "odometry_velocity_estimator_defines.svh"
module ove_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_s_tvalid,
    input wire logic          o_s_tready,
    input wire logic [191:0]  i_s_tdata,
    input wire logic          o_m_tvalid,
    input wire logic          i_m_tready,
    input wire logic [95:0]   o_m_tdata,
    input wire logic [1:0]    o_m_tuser
);
    import ove_pkg::*;

    logic w_in_xfer;
    assign w_in_xfer = i_s_tvalid && o_s_tready && (i_s_tdata[191:190] == 2'b00 || 1'b1);

    `OVE_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    `OVE_ASSERT_NOW(a_status_code, o_m_tvalid, o_m_tuser == ST_OK || o_m_tuser == ST_DT || o_m_tuser == ST_SAT)
    `OVE_ASSERT_NOW(a_bad_dt_zero, o_m_tvalid && o_m_tuser == ST_DT, o_m_tdata == 96'd0)
    `OVE_ASSERT_NEXT(a_busy_after_xfer, w_in_xfer, !o_s_tready)

endmodule

bind odometry_velocity_estimator ove_checker u_ove_checker (.*);
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the odometry velocity estimator.
`timescale 1ns / 1ps

import ove_pkg::*;

typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic [31:0]        sec;
    logic [29:0]        ns;
} t_odom_sample;

typedef struct {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] wr;
    logic [1:0]  st;
} t_velocity;

class velocity_scoreboard;
    t_velocity  pending_vel[$];
    int         errors;
    longint     prev_px, prev_py, last_heading, prev_sec, prev_ns;
    longint     atan_lut[16] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767
    };

    function void clear_state();
        prev_px = 0; prev_py = 0; last_heading = 0; prev_sec = 0; prev_ns = 0;
    endfunction

    function longint heading(longint y, longint x);
        longint z, xs, ys, r;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_lut[i];
            end else begin
                x -= ys; y += xs; z -= atan_lut[i];
            end
        end
        r = (z + 65536) >>> 17;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function void rotation(longint th, output longint c, output longint s);
        longint x, y, xs, ys;
        bit flip;
        x = longint'(KINV_Q30);
        y = 0;
        flip = 0;
        for (int k = 0; k < 2; k++) begin
            if (th > longint'(HALF_PI_Q30)) begin
                th -= longint'(PI_Q30); flip = !flip;
            end else if (th < -longint'(HALF_PI_Q30)) begin
                th += longint'(PI_Q30); flip = !flip;
            end
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (th >= 0) begin
                x -= ys; y += xs; th -= atan_lut[i];
            end else begin
                x += ys; y -= xs; th += atan_lut[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = (x + 2) >>> 2;
        s = (y + 2) >>> 2;
    endfunction

    function longint per_second(longint num, longint dt, int sh, inout bit sat);
        logic [127:0] d, n, q, lim;
        longint unsigned mag;
        bit neg;
        neg = num < 0;
        mag = neg ? -num : num;
        d = 128'(dt) << sh;
        n = 128'(mag) * 128'd1000000000 + (d >> 1);
        q = n / d;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim) begin
            sat = 1;
            q = lim;
        end
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function void note(t_odom_sample smp);
        longint px, py, num, den, yaw, dyaw, dt, c, s, dx, dy, mean;
        longint qx, qy, qz, qw;
        t_velocity e;
        bit sat;
        px = smp.px; py = smp.py;
        qx = smp.qx; qy = smp.qy; qz = smp.qz; qw = smp.qw;
        num = 2 * (qw * qz + qx * qy);
        den = (longint'(1) << 30) - 2 * (qy * qy + qz * qz);
        yaw = heading(num, den);
        dyaw = yaw - last_heading;
        if (dyaw > longint'(PI_Q13)) dyaw -= longint'(TWO_PI_Q13);
        else if (dyaw < -longint'(PI_Q13)) dyaw += longint'(TWO_PI_Q13);
        dt = (longint'(smp.sec) - prev_sec) * 1000000000 + (longint'(smp.ns) - prev_ns);
        e = '{vx: '0, vy: '0, wr: '0, st: ST_DT};
        if (dt > 0) begin
            sat = 0;
            dx = px - prev_px;
            dy = py - prev_py;
            mean = 2 * last_heading + dyaw;
            rotation(-mean * 65536, c, s);
            e.vx = 32'(per_second(c * dx - s * dy, dt, 28, sat));
            e.vy = 32'(per_second(s * dx + c * dy, dt, 28, sat));
            e.wr = 32'(per_second(dyaw * 8, dt, 0, sat));
            e.st = sat ? ST_SAT : ST_OK;
        end
        prev_px = px; prev_py = py; last_heading = yaw;
        prev_sec = smp.sec; prev_ns = smp.ns;
        pending_vel.push_back(e);
    endfunction

    function void check(t_velocity got);
        t_velocity e;
        if (pending_vel.size() == 0) begin
            $display("%0t: unexpected result vx=%h vy=%h wr=%h st=%0d",
                     $time, got.vx, got.vy, got.wr, got.st);
            errors++;
            return;
        end
        e = pending_vel.pop_front();
        if (got.vx !== e.vx) begin
            $display("%0t: vel_x exp %h got %h", $time, e.vx, got.vx); errors++;
        end
        if (got.vy !== e.vy) begin
            $display("%0t: vel_y exp %h got %h", $time, e.vy, got.vy); errors++;
        end
        if (got.wr !== e.wr) begin
            $display("%0t: yaw_rate exp %h got %h", $time, e.wr, got.wr); errors++;
        end
        if (got.st !== e.st) begin
            $display("%0t: status exp %0d got %0d", $time, e.st, got.st); errors++;
        end
    endfunction
endclass

module testbench;
    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [191:0] i_s_tdata;    // px, py, qx, qy, qz, qw, sec, ns from bit 0 up
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [95:0]  o_m_tdata;    // vel_x, vel_y, yaw_rate from bit 0 up
    logic [1:0]   o_m_tuser;    // status

    velocity_scoreboard sb;
    int           send_idle;
    int           recv_idle;
    int           hold_cycles;
    t_odom_sample cur;

    odometry_velocity_estimator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("testbench: FAIL");
        $finish;
    end

    // result side: ready drawn at the falling edge, transfers checked at the rising edge
    initial begin
        i_m_tready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_m_tready = 0;
            end else begin
                i_m_tready = ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check('{vx: o_m_tdata[31:0], vy: o_m_tdata[63:32],
                       wr: o_m_tdata[95:64], st: o_m_tuser});
    end

    task automatic send(t_odom_sample smp);
        while ($urandom_range(99) < send_idle) @(negedge i_clk);
        i_s_tvalid = 1;
        i_s_tdata = {2'b0, smp.ns, smp.sec, smp.qw, smp.qz, smp.qy, smp.qx, smp.py, smp.px};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note(smp);
        @(negedge i_clk);
        i_s_tvalid = 0;
    endtask

    task automatic drain();
        while (sb.pending_vel.size() != 0) @(negedge i_clk);
    endtask

    // mostly a moving robot with a forward clock; some samples are pure noise
    function automatic t_odom_sample next_sample();
        t_odom_sample s;
        int unsigned step;
        s = cur;
        if ($urandom_range(99) < 10) begin
            s.px = $urandom; s.py = $urandom;
            s.qx = 16'($urandom); s.qy = 16'($urandom);
            s.qz = 16'($urandom); s.qw = 16'($urandom);
            s.sec = $urandom; s.ns = 30'($urandom);
        end else begin
            if ($urandom_range(99) >= 3) begin
                step = $urandom_range(200000000, 1000);
                if (int'(cur.ns) + step >= 1000000000) begin
                    s.sec = cur.sec + 1;
                    s.ns = 30'(int'(cur.ns) + step - 1000000000);
                end else begin
                    s.ns = 30'(int'(cur.ns) + step);
                end
            end
            s.px = cur.px + $signed($urandom_range(2000000)) - 1000000;
            s.py = cur.py + $signed($urandom_range(2000000)) - 1000000;
            s.qx = 16'($signed($urandom_range(2000)) - 1000);
            s.qy = 16'($signed($urandom_range(2000)) - 1000);
            s.qz = 16'($urandom);
            s.qw = 16'($urandom);
        end
        return s;
    endfunction

    task automatic run_random(int n);
        repeat (n) begin
            cur = next_sample();
            send(cur);
        end
    endtask

    t_odom_sample directed[$];

    initial begin
        sb = new();
        sb.clear_state();
        send_idle = 0;
        recv_idle = 0;
        hold_cycles = 0;
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;

        directed.push_back('{0, 0, 0, 0, 0, 0, 0, 0});                        // same stamp as reset
        directed.push_back('{32'h10000, 32'h8000, 0, 0, 0, 32767, 1, 0});
        directed.push_back('{32'h20000, 0, 0, 0, 0, 32767, 1, 0});             // zero step
        directed.push_back('{32'h30000, 0, 0, 0, 0, 32767, 0, 500});           // backwards
        directed.push_back('{32'h30000, 32'h100, 0, 0, 0, 0, 2, 0});           // degenerate quat
        directed.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 32767, 2, 1}); // saturate
        directed.push_back('{32'h80000000, 32'h80000000, 0, 0, 0, 32767, 2, 2});
        directed.push_back('{0, 0, 0, 0, 32767, 0, 3, 0});                     // yaw near +pi
        directed.push_back('{32'h1000, 0, 0, 0, -32768, 1, 3, 1000});          // wraps to -pi
        directed.push_back('{-1, -1, -32768, -32768, -32768, -32768, 4, 0});
        directed.push_back('{5, 5, 32767, 32767, 0, 0, 4, 30'h3FFFFFFF});       // ns past a second
        directed.push_back('{6, 7, 0, 0, 100, 32767, 32'hFFFFFFFF, 0});
        directed.push_back('{8, 9, 0, 0, 0, 32767, 0, 0});                     // huge negative step
        directed.push_back('{100, 200, 0, 0, 23170, 23170, 0, 100000000});
        foreach (directed[k]) send(directed[k]);
        cur = directed[directed.size() - 1];
        drain();

        send_idle = 12;
        recv_idle = 80;
        run_random(220);
        send_idle = 80;
        recv_idle = 12;
        run_random(220);

        send_idle = 0;
        recv_idle = 0;
        hold_cycles = 600;
        run_random(8);
        drain();
        run_random(200);

        drain();
        repeat (250) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending_vel.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
